// ===== sv/ets_pkg.sv =====
`default_nettype none

package ets_pkg;

   // coordinate format: signed Q4.F
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = COORD_WIDTH - 4;
   localparam int FIELD_WIDTH = 32;
   localparam int IN_BITS     = (COORD_WIDTH < FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;
   localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
   localparam int MAG_WIDTH   = PROD_WIDTH + 1;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;

   // iteration limit register
   localparam int            CNT_WIDTH  = 8;
   localparam logic [CNT_WIDTH-1:0] ITER_RESET = CNT_WIDTH'(80);

   // |z|^2 limit of 4 with 2F fraction bits
   localparam logic [MAG_WIDTH-1:0] MAG_LIMIT = MAG_WIDTH'(1) << (2 * FRAC_BITS + 2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_TEST
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic update;
   } dp_cmd_type;

   typedef struct packed {
      logic escape;
   } dp_status_type;

   // low IN_BITS of an input field, sign extended to a coordinate
   function automatic logic signed [COORD_WIDTH-1:0] to_coord(
      input logic [FIELD_WIDTH-1:0] f
   );
      logic signed [IN_BITS-1:0] t;
      t = f[IN_BITS-1:0];
      return COORD_WIDTH'(t);
   endfunction

   // clamp a wide sum to the signed coordinate range
   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [SUM_WIDTH-1:0] x
   );
      logic signed [COORD_WIDTH-1:0] lo;
      logic                          fits;
      lo   = x[COORD_WIDTH-1:0];
      fits = (x == SUM_WIDTH'(lo));
      if (fits) begin
         return lo;
      end else if (x[SUM_WIDTH-1]) begin
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/ets_datapath.sv =====
`default_nettype none

module ets_datapath (
   input  wire logic                                 clock,
   input  wire ets_pkg::dp_cmd_type                  cmd,
   output      ets_pkg::dp_status_type               status,
   input  wire logic [ets_pkg::FIELD_WIDTH-1:0]      req_c_real,
   input  wire logic [ets_pkg::FIELD_WIDTH-1:0]      req_c_imag,
   input  wire logic [ets_pkg::FIELD_WIDTH-1:0]      req_start_real,
   input  wire logic [ets_pkg::FIELD_WIDTH-1:0]      req_start_imag
);

   logic signed [ets_pkg::COORD_WIDTH-1:0] c_re_ff, c_im_ff;
   logic signed [ets_pkg::COORD_WIDTH-1:0] z_re_ff, z_im_ff;
   logic signed [ets_pkg::COORD_WIDTH-1:0] z_re_in, z_im_in;
   logic signed [ets_pkg::PROD_WIDTH-1:0]  sq_re_ff, sq_im_ff, cross_ff;
   logic signed [ets_pkg::PROD_WIDTH-1:0]  sq_re_in, sq_im_in, cross_in;
   logic        [ets_pkg::MAG_WIDTH-1:0]   mag;
   logic signed [ets_pkg::SUM_WIDTH-1:0]   diff, re_sum, im_sum;

   // multiply stage: three independent products
   always_comb begin
      sq_re_in = z_re_ff * z_re_ff;
      sq_im_in = z_im_ff * z_im_ff;
      cross_in = z_re_ff * z_im_ff;
   end

   // test / update stage on the registered products
   always_comb begin
      mag    = ets_pkg::MAG_WIDTH'($unsigned(sq_re_ff))
             + ets_pkg::MAG_WIDTH'($unsigned(sq_im_ff));
      diff   = ets_pkg::SUM_WIDTH'(sq_re_ff) - ets_pkg::SUM_WIDTH'(sq_im_ff);
      re_sum = (diff >>> ets_pkg::FRAC_BITS) + ets_pkg::SUM_WIDTH'(c_re_ff);
      im_sum = ets_pkg::SUM_WIDTH'(cross_ff >>> (ets_pkg::FRAC_BITS - 1))
             + ets_pkg::SUM_WIDTH'(c_im_ff);
      z_re_in = ets_pkg::sat_coord(re_sum);
      z_im_in = ets_pkg::sat_coord(im_sum);
      status.escape = (mag > ets_pkg::MAG_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         c_re_ff <= ets_pkg::to_coord(req_c_real);
         c_im_ff <= ets_pkg::to_coord(req_c_imag);
         z_re_ff <= ets_pkg::to_coord(req_start_real);
         z_im_ff <= ets_pkg::to_coord(req_start_imag);
      end else if (cmd.update) begin
         z_re_ff <= z_re_in;
         z_im_ff <= z_im_in;
      end
      if (cmd.mul) begin
         sq_re_ff <= sq_re_in;
         sq_im_ff <= sq_im_in;
         cross_ff <= cross_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ets_ctrl.sv =====
`default_nettype none

module ets_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output      logic                            busy,
   input  wire logic [ets_pkg::CNT_WIDTH-1:0]   max_iterations,
   output      ets_pkg::dp_cmd_type             cmd,
   input  wire ets_pkg::dp_status_type          status,
   output      logic                            rsp_valid,
   output      logic                            rsp_in_set
);

   ets_pkg::state_type              state_ff, state_in;
   logic [ets_pkg::CNT_WIDTH-1:0]   iter_ff, iter_in, iter_next;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_in_set_ff, rsp_in_set_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ets_pkg::ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_in_set_ff <= rsp_in_set_in;
   end

   always_comb begin
      iter_next     = iter_ff + ets_pkg::CNT_WIDTH'(1);
      state_in      = state_ff;
      iter_in       = iter_ff;
      rsp_valid_in  = 1'b0;
      rsp_in_set_in = rsp_in_set_ff;
      cmd           = '0;
      unique case (state_ff)
         ets_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               iter_in  = '0;
               if (max_iterations == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in_set_in = 1'b1;
               end else begin
                  state_in = ets_pkg::ST_MUL;
               end
            end
         end
         ets_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ets_pkg::ST_TEST;
         end
         ets_pkg::ST_TEST: begin
            if (status.escape) begin
               rsp_valid_in  = 1'b1;
               rsp_in_set_in = 1'b0;
               state_in      = ets_pkg::ST_IDLE;
            end else if (iter_next == max_iterations) begin
               rsp_valid_in  = 1'b1;
               rsp_in_set_in = 1'b1;
               state_in      = ets_pkg::ST_IDLE;
            end else begin
               cmd.update = 1'b1;
               iter_in    = iter_next;
               state_in   = ets_pkg::ST_MUL;
            end
         end
         default: begin
            state_in = ets_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ets_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_in_set = rsp_in_set_ff;

endmodule

`default_nettype wire

// ===== sv/escape_time_set_test.sv =====
// Escape-time set membership test.
// Command side: drive req_c_real/req_c_imag (constant c) and
// req_start_real/req_start_imag (starting z), all signed Q4.28, and raise
// start. The transfer happens on a rising edge with start high and busy low.
// The block iterates z = z*z + c, testing |z|^2 > 4 before each update,
// for at most csr_wdata-programmed max_iterations (reset value 80).
// Result side: rsp_valid pulses for one cycle with rsp_in_set (1 = stayed
// bounded, 0 = escaped). The receiver cannot stall; each result must be
// taken in its strobe cycle.
// Timing: each iteration passes through the multiplier stage and then the
// compare/update stage, so the loop sets the rate. An item that runs n
// tests (n <= max_iterations) keeps busy high while it alternates between
// the multiply and test/update states, and its result strobes in the cycle
// after its last test/update state. max_iterations of 0 returns in_set = 1
// in the cycle after the transfer.
// A new start can be taken in the same cycle that a result is shown.
// csr_we writes max_iterations; write it only while the block is idle.
// Reset (synchronous, active high) returns to idle, drops any item in
// flight, and reloads max_iterations with 80.

`default_nettype none

module escape_time_set_test (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // command channel
   input  wire logic                                 start,
   output      logic                                 busy,
   input  wire logic [ets_pkg::FIELD_WIDTH-1:0]      req_c_real,
   input  wire logic [ets_pkg::FIELD_WIDTH-1:0]      req_c_imag,
   input  wire logic [ets_pkg::FIELD_WIDTH-1:0]      req_start_real,
   input  wire logic [ets_pkg::FIELD_WIDTH-1:0]      req_start_imag,
   // result channel
   output      logic                                 rsp_valid,
   output      logic                                 rsp_in_set,
   // configuration
   input  wire logic                                 csr_we,
   input  wire logic [ets_pkg::CNT_WIDTH-1:0]        csr_wdata
);

   logic [ets_pkg::CNT_WIDTH-1:0] max_iter_ff;
   ets_pkg::dp_cmd_type           cmd;
   ets_pkg::dp_status_type        status;

   // iteration limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= ets_pkg::ITER_RESET;
      end else if (csr_we) begin
         max_iter_ff <= csr_wdata;
      end
   end

   // sequencer: load, then alternate multiply and test/update
   ets_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .max_iterations (max_iter_ff),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_in_set     (rsp_in_set)
   );

   // z registers, product registers, magnitude compare and update
   ets_datapath u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .req_c_real     (req_c_real),
      .req_c_imag     (req_c_imag),
      .req_start_real (req_start_real),
      .req_start_imag (req_start_imag)
   );

endmodule

`default_nettype wire
